// ===== design/integer_square_root_rounded_unit_macros.svh =====
// assertion helpers used by isrr_core
`ifndef INTEGER_SQUARE_ROOT_ROUNDED_UNIT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_ROUNDED_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ISRR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ISRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/isrr_pkg.sv =====
`default_nettype none

package isrr_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ROUND
	} isrr_state_t;

	// top level to core
	typedef struct packed {
		logic start;
		logic res_ready;
	} isrr_ctrl_t;

	// core to top level
	typedef struct packed {
		logic idle;
		logic res_valid;
	} isrr_status_t;

endpackage

`default_nettype wire

// ===== design/isrr_core.sv =====
`default_nettype none

`include "integer_square_root_rounded_unit_macros.svh"

module isrr_core
	import isrr_pkg::*;
#(
	parameter int RADICAND_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire isrr_ctrl_t                    ctrl,
	input  wire logic [RADICAND_WIDTH-1:0]     radicand,
	output isrr_status_t                       status,
	output logic [RADICAND_WIDTH/2:0]          root
);

	localparam int DS = (RADICAND_WIDTH + 1) / 2;
	localparam int SW = 2 * DS;
	localparam int RW = RADICAND_WIDTH / 2 + 1;
	localparam int CW = $clog2(DS);

	isrr_state_t       state_q;
	isrr_state_t       state_d;
	logic [CW-1:0]     cnt_q;
	logic [SW-1:0]     rad_q;
	logic [DS+1:0]     rem_q;
	logic [DS:0]       root_q;

	logic [DS+1:0]     rem_sh;
	logic [DS+1:0]     trial;
	logic [DS+2:0]     diff;
	logic              fits;
	logic              round_up;
	logic [DS:0]       rounded;

	// one root bit per step: bring down two radicand bits, try (root << 2) | 1
	assign rem_sh   = {rem_q[DS-1:0], rad_q[SW-1 -: 2]};
	assign trial    = {root_q[DS-1:0], 2'b01};
	assign diff     = {1'b0, rem_sh} - {1'b0, trial};
	assign fits     = ~diff[DS+2];
	assign round_up = rem_q > {1'b0, root_q};
	assign rounded  = root_q + (DS+1)'(round_up);
	assign root     = rounded[RW-1:0];

	always_comb begin
		state_d          = state_q;
		status.idle      = 1'b0;
		status.res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				status.idle = 1'b1;
				if (ctrl.start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == '0) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				status.res_valid = 1'b1;
				if (ctrl.res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.start) begin
				cnt_q <= CW'(DS - 1);
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rad_q  <= SW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_RUN) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? diff[DS+1:0] : rem_sh;
			root_q <= {root_q[DS-1:0], fits};
		end
	end

	`ISRR_ASSERT_SAME(a_start_idle, ctrl.start, state_q == ST_IDLE, "start while busy")
	`ISRR_ASSERT_NEXT(a_last_step, (state_q == ST_RUN) && (cnt_q == '0), state_q == ST_ROUND, "missed rounding step")
	`ISRR_ASSERT_SAME(a_rem_bound, (state_q == ST_RUN) || (state_q == ST_ROUND), rem_q <= {root_q, 1'b0}, "remainder above twice the root")
	`ISRR_ASSERT_NEXT(a_hold_result, (state_q == ST_ROUND) && !ctrl.res_ready, (state_q == ST_ROUND) && $stable(root), "result lost while held")

endmodule

`default_nettype wire

// ===== design/integer_square_root_rounded_unit.sv =====
// integer square root, rounded to nearest
//
// input stream: s_tvalid/s_tready/s_tdata carries one radicand per transfer;
// only the low RADICAND_WIDTH bits of s_tdata are used.
// output stream: m_tvalid/m_tready/m_tdata carries the rounded root, one
// transfer per input transfer, in order.
// the root is built by a restoring digit-by-digit core, one root bit per
// cycle: (RADICAND_WIDTH+1)/2 steps, then a rounding state.
// one item is in the core at a time, so a new input is taken only once the
// core has handed its rounded root on to the output register and is idle.
// the output register parts the two sides: the core takes the next radicand
// while a finished root still waits in it. when the receiver stalls, the core
// holds its own finished root until the output register frees up.
// reset empties the output register and returns the core to idle.
`default_nettype none

module integer_square_root_rounded_unit
	import isrr_pkg::*;
#(
	parameter int RADICAND_WIDTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [((RADICAND_WIDTH+7)/8)*8-1:0]     s_tdata,  // radicand
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [((RADICAND_WIDTH/2+8)/8)*8-1:0]        m_tdata   // root
);

	localparam int RW    = RADICAND_WIDTH / 2 + 1;
	localparam int OUT_W = ((RW + 7) / 8) * 8;

	isrr_ctrl_t         ctrl;
	isrr_status_t       status;
	logic [RW-1:0]      root;
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;

	assign s_tready       = status.idle;
	assign ctrl.start     = s_tvalid & status.idle;
	assign ctrl.res_ready = ~m_valid_q | m_tready;

	isrr_core #(
		.RADICAND_WIDTH(RADICAND_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.radicand (s_tdata[RADICAND_WIDTH-1:0]),
		.status   (status),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.res_ready) begin
			m_valid_q <= status.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_ready && status.res_valid) begin
			m_data_q <= OUT_W'(root);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire
